FILE: rtl/core/pssm_pkg.sv
package pssm_pkg;

    localparam int unsigned CFG_W       = 6;
    localparam int unsigned WIDX_W      = 7;
    localparam int unsigned WGT_W       = 16;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned SCORE_W     = 21;
    localparam int unsigned POS_W       = 20;
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [1:0] t_code;

    localparam t_code CODE_A = 2'd0;
    localparam t_code CODE_G = 2'd1;
    localparam t_code CODE_C = 2'd2;
    localparam t_code CODE_T = 2'd3;

    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_BASE = 1'b1
    } t_func;

    typedef struct packed {
        t_func                     func;
        logic [WIDX_W-1:0]         weight_index;
        logic signed [WGT_W-1:0]   weight_value;
        logic [CHAR_W-1:0]         base_char;
        logic                      seq_start;
    } t_in_req;

    typedef struct packed {
        logic signed [SCORE_W-1:0] window_score;
        logic [POS_W-1:0]          window_start;
    } t_out_req;

    // classified request handed from front to back
    typedef struct packed {
        logic                      is_load;
        logic [WIDX_W-1:0]         weight_index;
        logic signed [WGT_W-1:0]   weight_value;
        t_code                     code;
        logic                      code_ok;
        logic                      emit;
        logic [LEN_W-1:0]          len_m1;
        logic [POS_W-1:0]          window_start;
    } t_op;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    typedef struct packed {
        logic  ok;
        t_code code;
    } t_base;

    function automatic t_base decode_base(input logic [CHAR_W-1:0] ch);
        t_base b;
        b.ok   = 1'b1;
        b.code = CODE_A;
        case (ch) inside
            CH_A_UP, CH_A_LO: b.code = CODE_A;
            CH_G_UP, CH_G_LO: b.code = CODE_G;
            CH_C_UP, CH_C_LO: b.code = CODE_C;
            CH_T_UP, CH_T_LO: b.code = CODE_T;
            default:          b.ok   = 1'b0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/pssm_front.sv
module pssm_front #(
    parameter int unsigned MAX_MOTIF = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pssm_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    input  pssm_pkg::t_in_req            i_in_req,
    input  logic                         i_q_full,
    output logic                         o_in_stall,
    output logic                         o_push,
    output pssm_pkg::t_op                o_op
);

    localparam int unsigned FILL_W = $clog2(MAX_MOTIF + 1);

    logic [pssm_pkg::CFG_W-1:0] r_motif_length;
    logic [pssm_pkg::POS_W-1:0] r_pos;
    logic [FILL_W-1:0]          r_fill;

    logic [pssm_pkg::POS_W-1:0] cur;
    logic [FILL_W-1:0]          n_fill;
    logic [pssm_pkg::LEN_W-1:0] len_m1;
    logic                       accept;
    logic                       is_base;
    pssm_pkg::t_base            dec;

    // clamp window width into 1..MAX_MOTIF
    always_comb begin
        if (r_motif_length == '0) begin
            len_m1 = '0;
        end else if (32'(r_motif_length) > 32'(MAX_MOTIF)) begin
            len_m1 = pssm_pkg::LEN_W'(MAX_MOTIF - 1);
        end else begin
            len_m1 = pssm_pkg::LEN_W'(r_motif_length - 1'b1);
        end
    end

    assign accept     = i_in_valid && !i_q_full;
    assign is_base    = (i_in_req.func == pssm_pkg::FUNC_BASE);
    assign o_in_stall = i_q_full;
    assign o_push     = accept;
    assign dec        = pssm_pkg::decode_base(i_in_req.base_char);

    always_comb begin
        cur = i_in_req.seq_start ? '0 : r_pos;
        if (i_in_req.seq_start) begin
            n_fill = FILL_W'(1);
        end else if (32'(r_fill) < 32'(MAX_MOTIF)) begin
            n_fill = r_fill + 1'b1;
        end else begin
            n_fill = r_fill;
        end
    end

    always_comb begin
        o_op.is_load      = !is_base;
        o_op.weight_index = i_in_req.weight_index;
        o_op.weight_value = i_in_req.weight_value;
        o_op.code         = dec.code;
        o_op.code_ok      = dec.ok;
        o_op.emit         = is_base && (32'(n_fill) > 32'(len_m1));
        o_op.len_m1       = len_m1;
        o_op.window_start = cur - pssm_pkg::POS_W'(len_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_length <= pssm_pkg::CFG_W'(1);
            r_pos          <= '0;
            r_fill         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_motif_length <= i_cfg_wdata;
            end
            if (accept && is_base) begin
                r_pos  <= cur + 1'b1;
                r_fill <= n_fill;
            end
        end
    end

endmodule

FILE: rtl/core/pssm_queue.sv
module pssm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pssm_pkg::t_op     i_push_op,
    input  logic              i_pop,
    output pssm_pkg::t_q_stat o_stat,
    output pssm_pkg::t_op     o_head
);

    localparam int unsigned PTR_W = $clog2(pssm_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(pssm_pkg::QUEUE_DEPTH + 1);

    pssm_pkg::t_op    r_mem [pssm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.full     = (32'(r_cnt) == 32'(pssm_pkg::QUEUE_DEPTH));
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_head          = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/pssm_back.sv
module pssm_back #(
    parameter int unsigned MAX_MOTIF = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pssm_pkg::t_q_stat i_stat,
    input  pssm_pkg::t_op     i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pssm_pkg::t_out_req o_out_req
);

    localparam int unsigned WGT_W   = pssm_pkg::WGT_W;
    localparam int unsigned SCORE_W = pssm_pkg::SCORE_W;
    localparam int unsigned PS_W    = WGT_W + $clog2(MAX_MOTIF);
    localparam int unsigned EXT_W   = (PS_W > SCORE_W) ? PS_W : SCORE_W;
    localparam int unsigned SEL_W   = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

    localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) << (SCORE_W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

    // per-position weight lanes, four bases each
    logic signed [WGT_W-1:0] r_w  [MAX_MOTIF][4];
    logic signed [PS_W-1:0]  r_ps [MAX_MOTIF];
    logic signed [PS_W-1:0]  lw   [MAX_MOTIF];
    logic signed [PS_W-1:0]  n_ps [MAX_MOTIF];

    logic                          r_out_valid;
    pssm_pkg::t_out_req            r_out_req;
    logic                          base_fire;
    logic signed [EXT_W-1:0]       sum_x;
    logic signed [SCORE_W-1:0]     score;

    assign o_pop = i_stat.nonempty &&
                   (!i_head.emit || !r_out_valid || !i_out_stall);
    assign base_fire = o_pop && !i_head.is_load;

    for (genvar j = 0; j < MAX_MOTIF; j++) begin : g_lane
        logic wr_hit;

        assign wr_hit = o_pop && i_head.is_load &&
                        (32'(i_head.weight_index[pssm_pkg::WIDX_W-1:2]) == j);
        assign lw[j]  = i_head.code_ok ? PS_W'(r_w[j][i_head.code]) : '0;

        if (j == 0) begin : g_first
            assign n_ps[j] = lw[j];
        end else begin : g_rest
            assign n_ps[j] = r_ps[j-1] + lw[j];
        end

        always_ff @(posedge i_clk) begin
            if (wr_hit) begin
                r_w[j][i_head.weight_index[1:0]] <= i_head.weight_value;
            end
            if (base_fire) begin
                r_ps[j] <= n_ps[j];
            end
        end
    end

    assign sum_x = EXT_W'(n_ps[i_head.len_m1[SEL_W-1:0]]);

    always_comb begin
        if (sum_x > SAT_HI) begin
            score = SCORE_W'(SAT_HI);
        end else if (sum_x < SAT_LO) begin
            score = SCORE_W'(SAT_LO);
        end else begin
            score = SCORE_W'(sum_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (base_fire && i_head.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (base_fire && i_head.emit) begin
            r_out_req.window_score <= score;
            r_out_req.window_start <= i_head.window_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

FILE: rtl/core/pssm_window_scorer.sv
// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid / o_in_stall  i_in_req  (pssm_pkg::t_in_req)
// out       source     o_out_valid / i_out_stall o_out_req (pssm_pkg::t_out_req)
// cfg       sink       i_cfg_we                 i_cfg_wdata (motif_length)
//
// One request per cycle, sustained unless o_in_stall is raised. A request
// is pushed into the classification queue on acceptance; once popped, a
// scoring base passes the systolic adder row into the output register.
// Reset is synchronous, active low; it clears position, fill count, queue and
// output valid, and sets motif_length to 1. Weights are not reset.
// o_in_stall rises only once the two-entry queue has filled behind a stalled
// output register.
module pssm_window_scorer #(
    parameter int unsigned MAX_MOTIF = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pssm_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pssm_pkg::t_in_req          i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pssm_pkg::t_out_req         o_out_req
);

    // front -> queue
    logic              push;
    pssm_pkg::t_op     push_op;
    // queue -> back
    pssm_pkg::t_q_stat q_stat;
    pssm_pkg::t_op     q_head;
    logic              pop;

    // Front: config register, sequence position and window fill tracking.
    // Decodes the character and decides whether this request emits a score.
    pssm_front #(
        .MAX_MOTIF (MAX_MOTIF)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .i_q_full    (q_stat.full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_op        (push_op)
    );

    // Short queue decouples front from output backpressure.
    pssm_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_stat    (q_stat),
        .o_head    (q_head)
    );

    // Back: weight lanes and systolic partial sums, one lane per motif
    // position. Loads write a lane; bases shift sums one lane along.
    pssm_back #(
        .MAX_MOTIF (MAX_MOTIF)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (q_stat),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

FILE: rtl/core/pssm_checker.sv
module pssm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input pssm_pkg::t_out_req         o_out_req
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("result changed while stalled");

    // reset leaves output empty and input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // input backpressure only with a result pending
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // stall follows a cycle of output backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind pssm_window_scorer pssm_checker u_pssm_checker (.*);

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pssm_pkg::*;

    localparam int MAX_MOTIF   = 32;
    localparam int TABLE_SIZE  = MAX_MOTIF * 4;
    // cycles with no request moving on either channel before the run is called hung
    localparam int QUIET_LIMIT = 1000;
    // settle time after the last expected score: pipeline depth plus margin
    localparam int SETTLE_CYC  = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 in_valid    = 1'b0;
    logic                 o_in_stall;
    t_in_req              in_req      = '0;
    logic                 o_out_valid;
    logic                 out_stall   = 1'b0;
    t_out_req             o_out_req;

    pssm_window_scorer #(
        .MAX_MOTIF(MAX_MOTIF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (o_out_req)
    );

    always #1ns i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoring model: weight table, systolic partial sums, fill and position
    // ------------------------------------------------------------------
    int             wgt_tbl [TABLE_SIZE];
    int             win_sum [MAX_MOTIF];
    int             fill_cnt  = 0;
    logic [POS_W-1:0] next_pos = '0;
    logic [CFG_W-1:0] motif_len = CFG_W'(1);

    t_in_req        pending_reqs [$];   // requests waiting for the driver
    t_out_req       score_q      [$];   // predicted window scores, oldest first

    int             err_cnt   = 0;
    int             score_cnt = 0;
    bit             calm      = 1'b0;   // no idling on either side when set
    int             send_gap  = 0;
    int             stall_gap = 0;
    int             quiet     = 0;

    initial begin
        foreach (wgt_tbl[k]) wgt_tbl[k] = 0;
        foreach (win_sum[k]) win_sum[k] = 0;
    end

    // case-insensitive ACGT decode; anything else does not match
    function automatic bit dna_code(input logic [CHAR_W-1:0] ch, output t_code code);
        code = CODE_A;
        case (ch)
            CH_A_UP, CH_A_LO: code = CODE_A;
            CH_G_UP, CH_G_LO: code = CODE_G;
            CH_C_UP, CH_C_LO: code = CODE_C;
            CH_T_UP, CH_T_LO: code = CODE_T;
            default:          return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Apply one accepted request to the model; a base request that completes
    // a window queues its expected score and start position.
    function automatic void score_request(input t_in_req rq);
        t_code            code;
        bit               hit;
        int               span;
        int               s;
        logic [POS_W-1:0] cur;
        t_out_req         exp_res;
        if (rq.func == FUNC_LOAD) begin
            // seq_start and base_char mean nothing on a load
            wgt_tbl[rq.weight_index] = int'(rq.weight_value);
            return;
        end
        hit = dna_code(rq.base_char, code);
        if (rq.seq_start) begin
            fill_cnt = 0;
            cur      = '0;
        end else begin
            cur = next_pos;
        end
        next_pos = cur + POS_W'(1);

        // each stage adds its own position's weight as the character passes
        for (int j = MAX_MOTIF - 1; j > 0; j--)
            win_sum[j] = win_sum[j-1] + (hit ? wgt_tbl[j*4 + int'(code)] : 0);
        win_sum[0] = hit ? wgt_tbl[int'(code)] : 0;
        if (fill_cnt < MAX_MOTIF) fill_cnt++;

        // 0 behaves as 1, anything past MAX_MOTIF as MAX_MOTIF
        span = (motif_len == 0) ? 1 : (int'(motif_len) > MAX_MOTIF ? MAX_MOTIF
                                                                    : int'(motif_len));
        if (fill_cnt < span) return;

        s = win_sum[span-1];
        if (s >  1048575) s =  1048575;
        if (s < -1048576) s = -1048576;
        exp_res.window_score = SCORE_W'(s);
        exp_res.window_start = cur - POS_W'(span - 1);
        score_q.push_back(exp_res);
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH score #%0d: %s", score_cnt, msg);
    endtask

    task automatic check_score(input t_out_req got);
        t_out_req want;
        if (score_q.size() == 0) begin
            report_mismatch($sformatf("unexpected score %0d start %0d",
                                      got.window_score, got.window_start));
            return;
        end
        want = score_q.pop_front();
        if (got.window_score !== want.window_score)
            report_mismatch($sformatf("window_score got %0d want %0d",
                                      got.window_score, want.window_score));
        if (got.window_start !== want.window_start)
            report_mismatch($sformatf("window_start got %0d want %0d",
                                      got.window_start, want.window_start));
        score_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver: holds a stalled request, idles in bursts unless calm
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) score_request(in_req);
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 8);
                in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                in_req   <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted score, stalls in bursts unless calm
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (o_out_valid && !out_stall) check_score(o_out_req);
            if (stall_gap != 0) begin
                stall_gap <= stall_gap - 1;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_gap <= $urandom_range(0, 8);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_in_req load_item(input int idx, input int val);
        t_in_req rq;
        rq.func         = FUNC_LOAD;
        rq.weight_index = WIDX_W'(idx);
        rq.weight_value = WGT_W'(val);
        rq.base_char    = CHAR_W'($urandom);
        rq.seq_start    = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic t_in_req base_item(input logic [CHAR_W-1:0] ch, input bit start);
        t_in_req rq;
        rq.func         = FUNC_BASE;
        rq.weight_index = WIDX_W'($urandom);
        rq.weight_value = WGT_W'($urandom);
        rq.base_char    = ch;
        rq.seq_start    = start;
        return rq;
    endfunction

    function automatic logic [CHAR_W-1:0] dna_char();
        case ($urandom_range(0, 7))
            0:       return CH_A_UP;
            1:       return CH_A_LO;
            2:       return CH_G_UP;
            3:       return CH_G_LO;
            4:       return CH_C_UP;
            5:       return CH_C_LO;
            6:       return CH_T_UP;
            default: return CH_T_LO;
        endcase
    endfunction

    // Wait until the block is idle: queue drained, last request taken,
    // every score back, then a settle wait for requests that give none.
    task automatic settle();
        while (pending_reqs.size() != 0 || in_valid) @(posedge i_clk);
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_motif_len(input logic [CFG_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        motif_len    = len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed DNA with rare restarts; some junk characters
    // and weight reloads in the middle of windows.
    task automatic random_phase(input int n);
        int pick;
        bit start;
        @(negedge i_clk);
        for (int k = 0; k < n; k++) begin
            pick  = $urandom_range(0, 99);
            start = ($urandom_range(0, 59) == 0);
            if (pick < 6)
                pending_reqs.push_back(load_item($urandom_range(0, TABLE_SIZE - 1), $urandom));
            else if (pick < 12)
                pending_reqs.push_back(base_item(CHAR_W'($urandom), start));
            else
                pending_reqs.push_back(base_item(dna_char(), start));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // motif length 1 after reset; junk characters score zero and need
        // no weights, so they can go before the table is loaded
        @(negedge i_clk);
        pending_reqs.push_back(base_item(8'h00, 1'b1));
        pending_reqs.push_back(base_item(8'hFF, 1'b0));
        pending_reqs.push_back(base_item(8'h4E, 1'b0));

        // whole table: A at the negative extreme, T at the positive one
        for (int p = 0; p < MAX_MOTIF; p++) begin
            pending_reqs.push_back(load_item(p*4 + int'(CODE_A), -32768));
            pending_reqs.push_back(load_item(p*4 + int'(CODE_G), p*1000 - 16000));
            pending_reqs.push_back(load_item(p*4 + int'(CODE_C), $urandom));
            pending_reqs.push_back(load_item(p*4 + int'(CODE_T), 32767));
        end

        // every letter in both cases
        pending_reqs.push_back(base_item(CH_A_UP, 1'b1));
        pending_reqs.push_back(base_item(CH_A_LO, 1'b0));
        pending_reqs.push_back(base_item(CH_G_UP, 1'b0));
        pending_reqs.push_back(base_item(CH_G_LO, 1'b0));
        pending_reqs.push_back(base_item(CH_C_UP, 1'b0));
        pending_reqs.push_back(base_item(CH_C_LO, 1'b0));
        pending_reqs.push_back(base_item(CH_T_UP, 1'b0));
        pending_reqs.push_back(base_item(CH_T_LO, 1'b0));
        settle();

        // widest window: all-A gives the most negative sum, all-T the largest
        set_motif_len(CFG_W'(MAX_MOTIF));
        @(negedge i_clk);
        for (int k = 0; k < MAX_MOTIF; k++)
            pending_reqs.push_back(base_item(k[0] ? CH_A_LO : CH_A_UP, k == 0));
        for (int k = 0; k < MAX_MOTIF; k++)
            pending_reqs.push_back(base_item(k[0] ? CH_T_LO : CH_T_UP, k == 0));
        // reload a weight mid-window: open windows keep what they already added
        pending_reqs.push_back(load_item((MAX_MOTIF - 1)*4 + int'(CODE_T), 0));
        pending_reqs.push_back(base_item(CH_T_UP, 1'b0));
        pending_reqs.push_back(base_item(CH_T_LO, 1'b0));
        settle();

        // random phases over several lengths, extremes included; the phase
        // boundaries also give the sender its full pause
        set_motif_len(6'd63);
        random_phase(140);
        settle();
        set_motif_len(6'd0);
        random_phase(140);
        settle();
        set_motif_len(6'd2);
        random_phase(140);
        settle();
        set_motif_len(CFG_W'(MAX_MOTIF));
        random_phase(140);
        settle();
        set_motif_len(6'd7);
        random_phase(140);
        settle();
        set_motif_len(6'd1);
        random_phase(140);
        settle();
        set_motif_len(CFG_W'($urandom_range(3, MAX_MOTIF - 1)));
        random_phase(140);
        settle();

        // final stretch at full rate on both sides
        calm = 1'b1;
        set_motif_len(6'd19);
        random_phase(160);
        settle();

        if (err_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pssm_pkg.sv
rtl/core/pssm_front.sv
rtl/core/pssm_queue.sv
rtl/core/pssm_back.sv
rtl/core/pssm_window_scorer.sv
rtl/core/pssm_checker.sv
tb/sv/tb.sv
